/* rtl/soi_pkg.sv */
// Package for the steered odometry integrator: widths, constants, CORDIC arctangent table.
// Used by every module of the block; depends on nothing.
package soi_pkg;
   localparam int TrigBitsDefault = 16;
   localparam int TrigBitsMax = 24;
   localparam logic [15:0] SpeedScaleReset = 16'd12353;
   localparam logic [15:0] InvWheelbaseReset = 16'd10779;
   localparam logic [31:0] CordicGain = 32'd652032874;
   localparam logic [31:0] TurnPerRad = 32'd683565276;

   localparam logic CSR_SPEED_SCALE = 1'b0;
   localparam logic CSR_INV_WHEELBASE = 1'b1;

   localparam logic REQ_COMMAND = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Datapath operation codes.
   typedef enum logic [3:0] {
      OP_NONE = 4'd0,
      OP_TRIG_INIT = 4'd1,
      OP_TRIG_STEP = 4'd2,
      OP_TRIG_DONE = 4'd3,
      OP_FWD = 4'd4,
      OP_TURN_A = 4'd5,
      OP_TURN_B = 4'd6,
      OP_VEL_A = 4'd7,
      OP_VEL_B = 4'd8,
      OP_VEL_C = 4'd9,
      OP_VEL_D = 4'd10,
      OP_POS_X = 4'd11,
      OP_POS_Y = 4'd12,
      OP_HEAD_A = 4'd13,
      OP_HEAD_B = 4'd14
   } op_type;

   typedef struct packed {
      op_type op;
      logic trig_heading;
   } cmd_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0: r = 32'd536870912;
         5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;
         5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;
         5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;
         5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;
         5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction
endpackage

/* rtl/soi_req_if.sv */
// Channel interfaces for request and response transactions.
// Depends on nothing.
interface soi_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic signed [15:0] wheel_rate;
   logic signed [15:0] lateral_speed;
   logic signed [15:0] steering_angle;
   logic [15:0] tick_interval;
   modport source (output valid, req_type, wheel_rate, lateral_speed, steering_angle,
                   tick_interval, input ready);
   modport sink (input valid, req_type, wheel_rate, lateral_speed, steering_angle,
                 tick_interval, output ready);
endinterface

interface soi_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [15:0] heading;
   logic signed [23:0] speed_x;
   logic signed [23:0] speed_y;
   logic signed [23:0] yaw_rate;
   modport source (output valid, pos_x, pos_y, heading, speed_x, speed_y, yaw_rate,
                   input ready);
   modport sink (input valid, pos_x, pos_y, heading, speed_x, speed_y, yaw_rate,
                 output ready);
endinterface

/* rtl/soi_datapath.sv */
// Datapath: CORDIC unit, sequenced multiply operations and the pose/velocity state.
// Depends on soi_pkg.
module soi_datapath #(
   parameter int TRIG_BITS = soi_pkg::TrigBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  soi_pkg::cmd_type cmd,
   input  logic [4:0] step_idx,
   input  logic [15:0] speed_scale,
   input  logic [15:0] inv_wheelbase,
   input  logic signed [15:0] wheel_rate,
   input  logic signed [15:0] lateral_speed,
   input  logic [15:0] steering_angle,
   input  logic [15:0] tick_interval,
   output logic signed [31:0] pos_x,
   output logic signed [31:0] pos_y,
   output logic [15:0] heading,
   output logic signed [23:0] speed_x,
   output logic signed [23:0] speed_y,
   output logic signed [23:0] yaw_rate
);
   import soi_pkg::*;

   localparam int RndC = 30 - TRIG_BITS;

   // Architectural state.
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic [15:0] head_ff, head_in;
   logic signed [23:0] fwd_ff, fwd_in, side_ff, side_in, turn_ff, turn_in;
   // CORDIC registers.
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic flip_ff, flip_in;
   logic signed [TRIG_BITS+2:0] cos_ff, cos_in, sin_ff, sin_in;
   // Scratch registers.
   logic signed [63:0] acc_ff, acc_in, tmp_ff, tmp_in;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
      logic signed [63:0] h;
      h = 64'sd1 <<< (s - 1);
      return (v + h) >>> s;
   endfunction

   function automatic logic signed [63:0] sat(input logic signed [63:0] v, input int bits);
      logic signed [63:0] hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   logic [31:0] ang, ang_f;
   logic fl;
   logic signed [33:0] sx, sy;

   always_comb begin
      x_in = x_ff; y_in = y_ff; head_in = head_ff;
      fwd_in = fwd_ff; side_in = side_ff; turn_in = turn_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; flip_in = flip_ff;
      cos_in = cos_ff; sin_in = sin_ff; acc_in = acc_ff; tmp_in = tmp_ff;
      ang = cmd.trig_heading ? {head_ff, 16'd0} : {steering_angle, 16'd0};
      fl = (ang + 32'h4000_0000) >= 32'h8000_0000;
      ang_f = fl ? ang - 32'h8000_0000 : ang;
      sx = cx_ff >>> step_idx;
      sy = cy_ff >>> step_idx;
      case (cmd.op)
         // Fold angle into the right half plane and load the CORDIC gain.
         OP_TRIG_INIT: begin
            flip_in = fl;
            cx_in = 34'(signed'(CordicGain));
            cy_in = '0;
            cz_in = 34'(signed'(ang_f));
         end
         // One micro-rotation per cycle.
         OP_TRIG_STEP: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               cz_in = cz_ff - 34'(atan_entry(step_idx));
            end else begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               cz_in = cz_ff + 34'(atan_entry(step_idx));
            end
         end
         OP_TRIG_DONE: begin
            cos_in = (TRIG_BITS+3)'(rnd(flip_ff ? -64'(cx_ff) : 64'(cx_ff), RndC));
            sin_in = (TRIG_BITS+3)'(rnd(flip_ff ? -64'(cy_ff) : 64'(cy_ff), RndC));
         end
         // Command: forward speed and lateral pass-through.
         OP_FWD: begin
            fwd_in = 24'(sat(rnd(64'(wheel_rate) * $signed({1'b0, speed_scale}), 8), 24));
            side_in = 24'(sat(64'(lateral_speed) * 64'sd256, 24));
         end
         OP_TURN_A: tmp_in = rnd(64'(fwd_ff) * 64'(sin_ff), TRIG_BITS);
         // The intermediate product stays within 25 bits, so a 32-bit slice suffices.
         OP_TURN_B:
            turn_in = 24'(sat(rnd(64'($signed(tmp_ff[31:0]))
                                  * $signed({1'b0, inv_wheelbase}), 12), 24));
         // Tick: rotate the body velocities into the world frame.
         OP_VEL_A: acc_in = 64'(fwd_ff) * 64'(cos_ff);
         OP_VEL_B: begin
            acc_in = rnd(acc_ff - 64'(side_ff) * 64'(sin_ff), TRIG_BITS);
            tmp_in = 64'(fwd_ff) * 64'(sin_ff);
         end
         OP_VEL_C: tmp_in = rnd(tmp_ff + 64'(side_ff) * 64'(cos_ff), TRIG_BITS);
         // World-frame velocities fit in 26 bits; integrate over the interval.
         OP_POS_X:
            x_in = 32'(sat(64'(x_ff) + rnd(64'($signed(acc_ff[31:0]))
                                           * $signed({48'd0, tick_interval}), 16), 32));
         OP_POS_Y:
            y_in = 32'(sat(64'(y_ff) + rnd(64'($signed(tmp_ff[31:0]))
                                           * $signed({48'd0, tick_interval}), 16), 32));
         OP_HEAD_A: acc_in = rnd(64'(turn_ff) * $signed({48'd0, tick_interval}), 8);
         OP_HEAD_B: begin
            // Split r * K into two narrow partial products to keep the multiply small.
            tmp_in = acc_ff * $signed({48'd0, TurnPerRad[15:0]});
         end
         OP_VEL_D: head_in = head_ff + 16'(rnd(
            (acc_ff * $signed({48'd0, TurnPerRad[31:16]})) * 64'sd65536 + tmp_ff, 40));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0; y_ff <= '0; head_ff <= '0;
         fwd_ff <= '0; side_ff <= '0; turn_ff <= '0;
      end else begin
         x_ff <= x_in; y_ff <= y_in; head_ff <= head_in;
         fwd_ff <= fwd_in; side_ff <= side_in; turn_ff <= turn_in;
      end
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; flip_ff <= flip_in;
      cos_ff <= cos_in; sin_ff <= sin_in; acc_ff <= acc_in; tmp_ff <= tmp_in;
   end

   assign pos_x = x_ff;
   assign pos_y = y_ff;
   assign heading = head_ff;
   assign speed_x = fwd_ff;
   assign speed_y = side_ff;
   assign yaw_rate = turn_ff;
endmodule

/* rtl/soi_control.sv */
// Controller: sequences the datapath for command and tick transactions.
// Depends on soi_pkg.
module soi_control #(
   parameter int TRIG_BITS = soi_pkg::TrigBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_kind,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic hold_load,
   output soi_pkg::cmd_type cmd,
   output logic [4:0] step_idx
);
   import soi_pkg::*;

   localparam int Steps = (TRIG_BITS < TrigBitsMax) ? TRIG_BITS : TrigBitsMax;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_INIT = 7'b0000010,
      ST_ROT  = 7'b0000100,
      ST_DONE = 7'b0001000,
      ST_SEQ  = 7'b0010000,
      ST_OUT  = 7'b0100000,
      ST_WAIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic kind_ff, kind_in;
   logic [2:0] seq_ff, seq_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign hold_load = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign step_idx = cnt_ff;

   // Next state and micro-operation selection.
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; kind_in = kind_ff; seq_in = seq_ff;
      cmd.op = OP_NONE;
      cmd.trig_heading = kind_ff;
      case (state_ff)
         ST_IDLE: if (hold_load) begin
            kind_in = req_kind;
            state_in = ST_WAIT;
         end
         ST_WAIT: state_in = ST_INIT;
         ST_INIT: begin
            cmd.op = OP_TRIG_INIT;
            cnt_in = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cmd.op = OP_TRIG_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(Steps - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.op = OP_TRIG_DONE;
            seq_in = '0;
            state_in = ST_SEQ;
         end
         ST_SEQ: begin
            seq_in = seq_ff + 3'd1;
            if (kind_ff == REQ_COMMAND) begin
               case (seq_ff)
                  3'd0: cmd.op = OP_FWD;
                  3'd1: cmd.op = OP_TURN_A;
                  default: begin
                     cmd.op = OP_TURN_B;
                     state_in = ST_IDLE;
                  end
               endcase
            end else begin
               case (seq_ff)
                  3'd0: cmd.op = OP_VEL_A;
                  3'd1: cmd.op = OP_VEL_B;
                  3'd2: cmd.op = OP_VEL_C;
                  3'd3: cmd.op = OP_POS_X;
                  3'd4: cmd.op = OP_POS_Y;
                  3'd5: cmd.op = OP_HEAD_A;
                  3'd6: cmd.op = OP_HEAD_B;
                  default: begin
                     cmd.op = OP_VEL_D;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         kind_ff <= 1'b0;
         seq_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         kind_ff <= kind_in;
         seq_ff <= seq_in;
      end
   end
endmodule

/* rtl/steered_odometry_integrator.sv */
// Steered odometry integrator top level: input hold registers, CSRs, controller, datapath.
// Each transaction runs the CORDIC rotation loop, then its command or tick operation
// sequence; a tick then waits for its result to be taken.
// One transaction at a time; the result register holds until taken.
// Synchronous reset clears pose, held speeds and the controller; CSRs return to defaults.
// Depends on soi_pkg, soi_req_if, soi_rsp_if, soi_control and soi_datapath.
module steered_odometry_integrator #(
   parameter int TRIG_BITS = soi_pkg::TrigBitsDefault
) (
   input  logic clock,
   input  logic reset,
   soi_req_if.sink req,
   soi_rsp_if.source rsp,
   input  logic csr_write_enable,
   input  logic csr_index,
   input  logic [15:0] csr_write_data
);
   import soi_pkg::*;

   logic [15:0] scale_ff, invwb_ff;
   logic signed [15:0] wr_ff, lat_ff;
   logic [15:0] steer_ff, dt_ff;
   logic hold_load;
   cmd_type cmd;
   logic [4:0] step_idx;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SpeedScaleReset;
         invwb_ff <= InvWheelbaseReset;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_SPEED_SCALE) scale_ff <= csr_write_data;
         else invwb_ff <= csr_write_data;
      end
   end

   // Hold the accepted transaction's fields.
   always_ff @(posedge clock) begin
      if (hold_load) begin
         wr_ff <= req.wheel_rate;
         lat_ff <= req.lateral_speed;
         steer_ff <= req.steering_angle;
         dt_ff <= req.tick_interval;
      end
   end

   soi_control #(.TRIG_BITS(TRIG_BITS)) u_control (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_kind(req.req_type),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .hold_load, .cmd, .step_idx
   );

   soi_datapath #(.TRIG_BITS(TRIG_BITS)) u_datapath (
      .clock, .reset, .cmd, .step_idx,
      .speed_scale(scale_ff), .inv_wheelbase(invwb_ff),
      .wheel_rate(wr_ff), .lateral_speed(lat_ff),
      .steering_angle(steer_ff), .tick_interval(dt_ff),
      .pos_x(rsp.pos_x), .pos_y(rsp.pos_y), .heading(rsp.heading),
      .speed_x(rsp.speed_x), .speed_y(rsp.speed_y), .yaw_rate(rsp.yaw_rate)
   );
endmodule

/* dv/tb_steered_odometry_integrator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the steered odometry integrator: directed table, random
// commands and ticks, configuration phases. Depends on soi_pkg, soi_req_if, soi_rsp_if.
module tb_steered_odometry_integrator;
   import soi_pkg::*;

   localparam int TrigSteps = 16;
   localparam int SettleCycles = 60;
   localparam int StallLimit = 20000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0] hdg;
      logic signed [23:0] vfwd;
      logic signed [23:0] vside;
      logic signed [23:0] wz;
   } pose_type;

   typedef struct {
      logic kind;
      logic signed [15:0] wheel;
      logic signed [15:0] lat;
      logic signed [15:0] steer;
      logic [15:0] dt;
      bit typed;
      pose_type pose;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic csr_index;
   logic [15:0] csr_write_data;

   soi_req_if req ();
   soi_rsp_if rsp ();

   steered_odometry_integrator #(.TRIG_BITS(TrigSteps)) uut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #10 clock = ~clock;

   // Predicted vehicle state and held configuration.
   longint pred_x, pred_y, pred_fwd, pred_side, pred_turn;
   logic [15:0] pred_heading;
   longint pred_scale, pred_invwb;
   pose_type pending_poses[$];
   int errors = 0;
   int ticks_sent = 0, cmds_sent = 0, poses_checked = 0;
   int idle_cycles = 0;

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint arctan_step(int i);
      longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
         10430, 5215, 2608, 1304, 652, 326, 163, 81};
      return tab[i];
   endfunction

   // Rotation-based sine and cosine of a 32-bit binary angle, Q1.16 results.
   task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
      logic [31:0] a, folded;
      bit flip;
      longint cx, cy, z, nx;
      a = ang;
      flip = 0;
      folded = a + 32'h4000_0000;
      if (folded >= 32'h8000_0000) begin
         a = a - 32'h8000_0000;
         flip = 1;
      end
      z = longint'($signed(a));
      cx = 652032874;
      cy = 0;
      for (int i = 0; i < TrigSteps; i++) begin
         if (z >= 0) begin
            nx = cx - (cy >>> i);
            cy = cy + (cx >>> i);
            z -= arctan_step(i);
         end else begin
            nx = cx + (cy >>> i);
            cy = cy - (cx >>> i);
            z += arctan_step(i);
         end
         cx = nx;
      end
      if (flip) begin
         cx = -cx;
         cy = -cy;
      end
      c = round_shift(cx, 30 - TrigSteps);
      s = round_shift(cy, 30 - TrigSteps);
   endtask

   // Advance the predicted state by one accepted transaction.
   task automatic integrate_item(input stim_row_type r);
      longint c, s, vx, vy, turn, dh, p;
      pose_type pz;
      if (r.kind == REQ_COMMAND) begin
         pred_fwd = clamp(round_shift(longint'(r.wheel) * pred_scale, 8), 24);
         pred_side = clamp(longint'(r.lat) * 256, 24);
         sin_cos({r.steer, 16'h0}, c, s);
         p = round_shift(pred_fwd * s, TrigSteps);
         pred_turn = clamp(round_shift(p * pred_invwb, 12), 24);
         return;
      end
      sin_cos({pred_heading, 16'h0}, c, s);
      vx = round_shift(pred_fwd * c - pred_side * s, TrigSteps);
      vy = round_shift(pred_fwd * s + pred_side * c, TrigSteps);
      pred_x = clamp(pred_x + round_shift(vx * longint'(r.dt), 16), 32);
      pred_y = clamp(pred_y + round_shift(vy * longint'(r.dt), 16), 32);
      turn = round_shift(pred_turn * longint'(r.dt), 8);
      dh = round_shift(turn * 683565276, 40);
      pred_heading = pred_heading + dh[15:0];
      pz.x = pred_x[31:0];
      pz.y = pred_y[31:0];
      pz.hdg = pred_heading;
      pz.vfwd = pred_fwd[23:0];
      pz.vside = pred_side[23:0];
      pz.wz = pred_turn[23:0];
      pending_poses.push_back(r.typed ? r.pose : pz);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // Drive one transaction and hold it until the block takes it.
   task automatic send_item(input stim_row_type r, input bit random_gap);
      int gap;
      req.valid <= 1'b1;
      req.req_type <= r.kind;
      req.wheel_rate <= r.wheel;
      req.lateral_speed <= r.lat;
      req.steering_angle <= r.steer;
      req.tick_interval <= r.dt;
      do @(posedge clock); while (!req.ready);
      integrate_item(r);
      if (r.kind == REQ_TICK) ticks_sent++;
      else cmds_sent++;
      gap = 0;
      if (random_gap && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      if (gap > 0) begin
         req.valid <= 1'b0;
         req.req_type <= 1'($urandom_range(0, 1));
         req.tick_interval <= 16'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait for all results, let the block settle, then write both registers.
   task automatic load_settings(input logic [15:0] scale, input logic [15:0] invwb);
      req.valid <= 1'b0;
      wait (pending_poses.size() == 0);
      repeat (SettleCycles) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SPEED_SCALE;
      csr_write_data <= scale;
      @(posedge clock);
      csr_index <= CSR_INV_WHEELBASE;
      csr_write_data <= invwb;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      pred_scale = scale;
      pred_invwb = invwb;
   endtask

   function automatic stim_row_type random_row(int tick_pct);
      stim_row_type r;
      r.kind = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_COMMAND;
      r.wheel = 16'($urandom);
      r.lat = 16'($urandom);
      r.steer = 16'($urandom);
      case ($urandom_range(0, 5))
         0: r.dt = 16'hFFFF;
         1: r.dt = 16'h0;
         2: r.dt = 16'($urandom_range(0, 255));
         default: r.dt = 16'($urandom);
      endcase
      r.typed = 0;
      r.pose = '0;
      return r;
   endfunction

   function automatic stim_row_type row(logic kind, logic [15:0] wheel, logic [15:0] lat,
                                        logic [15:0] steer, logic [15:0] dt, bit typed);
      stim_row_type r;
      r.kind = kind;
      r.wheel = wheel;
      r.lat = lat;
      r.steer = steer;
      r.dt = dt;
      r.typed = typed;
      r.pose = '0;
      return r;
   endfunction

   // Result acceptance and field-by-field comparison.
   always @(posedge clock) begin
      pose_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_poses.size() == 0) begin
            report_mismatch("result count", poses_checked + 1, ticks_sent);
         end else begin
            want = pending_poses.pop_front();
            poses_checked++;
            if (rsp.pos_x !== want.x) report_mismatch("pos_x", rsp.pos_x, want.x);
            if (rsp.pos_y !== want.y) report_mismatch("pos_y", rsp.pos_y, want.y);
            if (rsp.heading !== want.hdg) report_mismatch("heading", rsp.heading, want.hdg);
            if (rsp.speed_x !== want.vfwd) report_mismatch("speed_x", rsp.speed_x, want.vfwd);
            if (rsp.speed_y !== want.vside)
               report_mismatch("speed_y", rsp.speed_y, want.vside);
            if (rsp.yaw_rate !== want.wz) report_mismatch("yaw_rate", rsp.yaw_rate, want.wz);
         end
      end
   end

   // Receiver back-pressure: mostly short stalls, a few long ones, runs of none.
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 4);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("Watchdog expired with %0d results outstanding", pending_poses.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   stim_row_type directed[$];
   logic [15:0] phase_scale[4] = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0000};
   logic [15:0] phase_invwb[4] = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0000};

   initial begin
      stim_row_type r;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.req_type <= REQ_COMMAND;
      req.wheel_rate <= '0;
      req.lateral_speed <= '0;
      req.steering_angle <= '0;
      req.tick_interval <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_SPEED_SCALE;
      csr_write_data <= '0;
      pred_x = 0; pred_y = 0; pred_heading = '0;
      pred_fwd = 0; pred_side = 0; pred_turn = 0;
      pred_scale = SpeedScaleReset;
      pred_invwb = InvWheelbaseReset;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: pose after reset is all zero, whatever the interval.
      directed.push_back(row(REQ_TICK, 16'h7FFF, 16'h8000, 16'h4000, 16'h0000, 1));
      directed.push_back(row(REQ_TICK, 16'h8000, 16'h7FFF, 16'hC000, 16'hFFFF, 1));
      directed.push_back(row(REQ_COMMAND, 16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 0));
      directed.push_back(row(REQ_TICK, 0, 0, 0, 16'hFFFF, 0));
      directed.push_back(row(REQ_TICK, 0, 0, 0, 16'h0000, 0));
      directed.push_back(row(REQ_COMMAND, 16'h8000, 16'h7FFF, 16'h4000, 0, 0));
      directed.push_back(row(REQ_TICK, 0, 0, 0, 16'd1000, 0));
      directed.push_back(row(REQ_COMMAND, 16'h0100, 16'h8000, 16'h8000, 0, 0));
      directed.push_back(row(REQ_TICK, 0, 0, 0, 16'hFFFF, 0));
      directed.push_back(row(REQ_COMMAND, 16'h7FFF, 16'h7FFF, 16'h2000, 0, 0));
      for (int i = 0; i < 6; i++)
         directed.push_back(row(REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
      directed.push_back(row(REQ_COMMAND, 16'hFFFF, 16'h0001, 16'h7FFF, 0, 0));
      directed.push_back(row(REQ_TICK, 0, 0, 0, 16'h0001, 0));
      directed.push_back(row(REQ_COMMAND, 16'h0000, 16'h0000, 16'h0000, 0, 0));
      directed.push_back(row(REQ_TICK, 0, 0, 0, 16'h8000, 0));
      foreach (directed[i]) send_item(directed[i], 1);

      // Each phase runs with new register values, ending at the reset defaults.
      for (int ph = 0; ph < 5; ph++) begin
         if (ph < 4) load_settings(phase_scale[ph] == 0 && ph == 3 ? 16'($urandom)
                                                                   : phase_scale[ph],
                                   phase_invwb[ph] == 0 && ph == 3 ? 16'($urandom)
                                                                   : phase_invwb[ph]);
         else load_settings(SpeedScaleReset, InvWheelbaseReset);
         if (ph == 0) begin
            // Drive straight at top speed long enough to pin both positions at the limit.
            send_item(row(REQ_COMMAND, 16'h7FFF, 16'h7FFF, 16'h0000, 0, 0), 0);
            for (int i = 0; i < 270; i++)
               send_item(row(REQ_TICK, 0, 0, 0, 16'hFFFF, 0), i > 260);
         end
         for (int i = 0; i < 55; i++) begin
            r = random_row(70);
            send_item(r, ($urandom_range(0, 3) != 0) && (i < 40));
         end
      end

      req.valid <= 1'b0;
      wait (pending_poses.size() == 0);
      repeat (SettleCycles) @(posedge clock);
      $display("Covered %0d commands and %0d ticks over five register settings;",
               cmds_sent, ticks_sent);
      $display("%0d poses compared, %0d field mismatches.", poses_checked, errors);
      if (errors == 0 && pending_poses.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

/* files.f */
rtl/soi_pkg.sv
rtl/soi_req_if.sv
rtl/soi_datapath.sv
rtl/soi_control.sv
rtl/steered_odometry_integrator.sv
dv/tb_steered_odometry_integrator.sv
